>>> rtl/core/mmcsbt_pkg.sv
// Shared types and constants for the SPI-mode card block transfer engine.
// No dependencies; imported by mmcsbt_ctrl and mmc_spi_block_transfer_top.
package mmcsbt_pkg;

  localparam int BLOCK_BYTES = 512;
  localparam int BYTE_CNT_W  = 10;
  localparam int TRY_CNT_W   = 16;
  localparam int CFG_IDX_W   = 2;
  localparam int CFG_DATA_W  = 16;
  localparam int RESP_LIM_W  = 12;
  localparam int TOK_LIM_W   = 12;
  localparam int BUSY_LIM_W  = 16;

  localparam logic [BYTE_CNT_W-1:0] LAST_DATA_IDX = BYTE_CNT_W'(BLOCK_BYTES - 1);

  // action codes
  localparam logic [1:0] ACT_READ  = 2'd0;
  localparam logic [1:0] ACT_WRITE = 2'd1;
  localparam logic [1:0] ACT_SLOT  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_RESP_LIMIT = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOK_LIMIT  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_BUSY_LIMIT = 2'd2;

  // status codes
  localparam logic [1:0] ST_OK       = 2'd0;
  localparam logic [1:0] ST_REJECTED = 2'd1;
  localparam logic [1:0] ST_TOK_TMO  = 2'd2;
  localparam logic [1:0] ST_BUSY_TMO = 2'd3;

  // bytes on the wire
  localparam logic [7:0] CMD_BASE    = 8'h40;
  localparam logic [7:0] CMD_READ    = 8'd17;
  localparam logic [7:0] CMD_WRITE   = 8'd24;
  localparam logic [7:0] FRAME_CRC   = 8'h95;
  localparam logic [7:0] START_TOKEN = 8'hFE;
  localparam logic [7:0] IDLE_BYTE   = 8'hFF;
  localparam logic [7:0] BUSY_BYTE   = 8'h00;
  localparam logic [2:0] RESP_ACCEPT = 3'd2;

  typedef struct packed {
    logic [1:0]  action;
    logic [31:0] block_address;
    logic [7:0]  rx_byte;
    logic [7:0]  write_byte;
  } in_item_t;

  typedef struct packed {
    logic [7:0] tx_byte;
    logic       card_select;
    logic       take_write;
    logic       read_valid;
    logic [7:0] read_byte;
    logic       done_res;
    logic [1:0] status;
    logic [2:0] reject_code;
  } out_item_t;

  typedef struct packed {
    logic [RESP_LIM_W-1:0] resp_limit;
    logic [TOK_LIM_W-1:0]  tok_limit;
    logic [BUSY_LIM_W-1:0] busy_limit;
  } limits_t;

endpackage

>>> rtl/core/mmcsbt_ctrl.sv
// Transfer sequencer: phase state, counters and the per-byte result decode.
// Depends on mmcsbt_pkg.
module mmcsbt_ctrl import mmcsbt_pkg::*; (
  input  logic      clk,
  input  logic      rst_n,
  input  logic      fire,
  input  in_item_t  item,
  input  limits_t   lim,
  output out_item_t res
);

  localparam logic [3:0] PH_IDLE  = 4'd0;
  localparam logic [3:0] PH_FRAME = 4'd1;
  localparam logic [3:0] PH_R1    = 4'd2;
  localparam logic [3:0] PH_TOKEN = 4'd3;
  localparam logic [3:0] PH_RDATA = 4'd4;
  localparam logic [3:0] PH_RCRC  = 4'd5;
  localparam logic [3:0] PH_WDATA = 4'd6;
  localparam logic [3:0] PH_WTAIL = 4'd7;
  localparam logic [3:0] PH_BUSY  = 4'd8;

  logic [3:0]            phase_r, phase_nxt;
  logic                  is_write_r, is_write_nxt;
  logic [31:0]           addr_r, addr_nxt;
  logic [BYTE_CNT_W-1:0] byte_cnt_r, byte_cnt_nxt;
  logic [TRY_CNT_W-1:0]  try_cnt_r, try_cnt_nxt;

  logic [7:0] frame_byte;
  logic [2:0] resp_code;
  logic       finish;

  always_comb begin
    case (byte_cnt_r)
      BYTE_CNT_W'(1): frame_byte = addr_r[31:24];
      BYTE_CNT_W'(2): frame_byte = addr_r[23:16];
      BYTE_CNT_W'(3): frame_byte = addr_r[15:8];
      BYTE_CNT_W'(4): frame_byte = addr_r[7:0];
      default:        frame_byte = FRAME_CRC;
    endcase
  end

  assign resp_code = item.rx_byte[3:1];

  always_comb begin
    phase_nxt    = phase_r;
    is_write_nxt = is_write_r;
    addr_nxt     = addr_r;
    byte_cnt_nxt = byte_cnt_r;
    try_cnt_nxt  = try_cnt_r;
    finish       = 1'b0;
    res          = '0;
    res.tx_byte     = IDLE_BYTE;
    res.card_select = 1'b1;

    if (item.action == ACT_READ || item.action == ACT_WRITE) begin
      // a start abandons whatever is running
      is_write_nxt = item.action[0];
      addr_nxt     = item.block_address;
      phase_nxt    = PH_FRAME;
      try_cnt_nxt  = '0;
      byte_cnt_nxt = BYTE_CNT_W'(1);
      res.tx_byte  = CMD_BASE + (item.action[0] ? CMD_WRITE : CMD_READ);
    end else begin
      case (phase_r)
        PH_FRAME: begin
          if (byte_cnt_r <= BYTE_CNT_W'(5)) begin
            res.tx_byte  = frame_byte;
            byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
          end else begin
            phase_nxt   = PH_R1;
            try_cnt_nxt = TRY_CNT_W'(1);
          end
        end
        PH_R1: begin
          if (!item.rx_byte[7] || try_cnt_r >= TRY_CNT_W'(lim.resp_limit)) begin
            if (is_write_r) begin
              res.tx_byte  = START_TOKEN;
              phase_nxt    = PH_WDATA;
              byte_cnt_nxt = '0;
            end else begin
              phase_nxt   = PH_TOKEN;
              try_cnt_nxt = TRY_CNT_W'(1);
            end
          end else begin
            try_cnt_nxt = try_cnt_r + TRY_CNT_W'(1);
          end
        end
        PH_TOKEN: begin
          if (item.rx_byte == START_TOKEN) begin
            phase_nxt    = PH_RDATA;
            byte_cnt_nxt = '0;
          end else if (try_cnt_r >= TRY_CNT_W'(lim.tok_limit)) begin
            finish     = 1'b1;
            res.status = ST_TOK_TMO;
          end else begin
            try_cnt_nxt = try_cnt_r + TRY_CNT_W'(1);
          end
        end
        PH_RDATA: begin
          res.read_valid = 1'b1;
          res.read_byte  = item.rx_byte;
          if (byte_cnt_r >= LAST_DATA_IDX) begin
            phase_nxt    = PH_RCRC;
            byte_cnt_nxt = '0;
          end else begin
            byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
          end
        end
        PH_RCRC: begin
          if (byte_cnt_r == '0) begin
            byte_cnt_nxt = BYTE_CNT_W'(1);
          end else begin
            finish = 1'b1;
          end
        end
        PH_WDATA: begin
          res.tx_byte    = item.write_byte;
          res.take_write = 1'b1;
          if (byte_cnt_r >= LAST_DATA_IDX) begin
            phase_nxt    = PH_WTAIL;
            byte_cnt_nxt = '0;
          end else begin
            byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
          end
        end
        PH_WTAIL: begin
          // two CRC bytes, one gap byte, then the data response
          if (byte_cnt_r < BYTE_CNT_W'(3)) begin
            byte_cnt_nxt = byte_cnt_r + BYTE_CNT_W'(1);
          end else if (resp_code != RESP_ACCEPT) begin
            finish          = 1'b1;
            res.status      = ST_REJECTED;
            res.reject_code = resp_code;
          end else begin
            phase_nxt   = PH_BUSY;
            try_cnt_nxt = TRY_CNT_W'(1);
          end
        end
        PH_BUSY: begin
          if (item.rx_byte != BUSY_BYTE) begin
            finish = 1'b1;
          end else if (try_cnt_r >= TRY_CNT_W'(lim.busy_limit)) begin
            finish     = 1'b1;
            res.status = ST_BUSY_TMO;
          end else begin
            try_cnt_nxt = try_cnt_r + TRY_CNT_W'(1);
          end
        end
        default: begin
          phase_nxt       = PH_IDLE;
          res.card_select = 1'b0;
        end
      endcase
      if (finish) begin
        phase_nxt       = PH_IDLE;
        res.card_select = 1'b0;
        res.done_res    = 1'b1;
        res.tx_byte     = IDLE_BYTE;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r    <= PH_IDLE;
      is_write_r <= 1'b0;
      addr_r     <= '0;
      byte_cnt_r <= '0;
      try_cnt_r  <= '0;
    end else if (fire) begin
      phase_r    <= phase_nxt;
      is_write_r <= is_write_nxt;
      addr_r     <= addr_nxt;
      byte_cnt_r <= byte_cnt_nxt;
      try_cnt_r  <= try_cnt_nxt;
    end
  end

endmodule

>>> rtl/core/mmc_spi_block_transfer_top.sv
// Datapath: an accepted input transaction passes through the input register, then the result
// register, before out_valid rises with its result.
// Throughput: one transaction per cycle; in_stall is high only while the input register
// holds a transaction and the result register is full and stalled.
// Reset (rst_n low, synchronous): idle phase, counters and latched address cleared,
// limits back to 1024 / 1024 / 65535, both pipeline registers empty. Uses mmcsbt_pkg, mmcsbt_ctrl.
module mmc_spi_block_transfer_top import mmcsbt_pkg::*; (
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_valid,
  output logic                  in_stall,
  input  in_item_t              in_data,
  output logic                  out_valid,
  input  logic                  out_stall,
  output out_item_t             out_data,
  input  logic                  cfg_we,
  input  logic [CFG_IDX_W-1:0]  cfg_index,
  input  logic [CFG_DATA_W-1:0] cfg_wdata
);

  limits_t   lim_r;
  logic      s1_valid_r;
  in_item_t  s1_item_r;
  logic      out_valid_r;
  out_item_t out_item_r;
  out_item_t res;
  logic      out_free;
  logic      s1_fire;

  assign out_free = !out_valid_r || !out_stall;
  assign s1_fire  = s1_valid_r && out_free;
  assign in_stall = s1_valid_r && !out_free;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      lim_r.resp_limit <= RESP_LIM_W'(1024);
      lim_r.tok_limit  <= TOK_LIM_W'(1024);
      lim_r.busy_limit <= BUSY_LIM_W'(65535);
    end else if (cfg_we) begin
      case (cfg_index)
        REG_RESP_LIMIT: lim_r.resp_limit <= cfg_wdata[RESP_LIM_W-1:0];
        REG_TOK_LIMIT:  lim_r.tok_limit  <= cfg_wdata[TOK_LIM_W-1:0];
        REG_BUSY_LIMIT: lim_r.busy_limit <= cfg_wdata[BUSY_LIM_W-1:0];
        default: ;
      endcase
    end
  end

  // input register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r <= 1'b0;
    end else if (!in_stall) begin
      s1_valid_r <= in_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (!in_stall && in_valid) begin
      s1_item_r <= in_data;
    end
  end

  mmcsbt_ctrl u_ctrl (
    .clk   (clk),
    .rst_n (rst_n),
    .fire  (s1_fire),
    .item  (s1_item_r),
    .lim   (lim_r),
    .res   (res)
  );

  // result register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (out_free) begin
      out_valid_r <= s1_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire) begin
      out_item_r <= res;
    end
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_item_r;

`ifndef NO_ASSERTIONS
  a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    in_stall |-> s1_valid_r && out_valid_r)
    else $error("input stalled with an empty input register");

  a_done_releases_cs: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.done_res |-> !out_data.card_select)
    else $error("done transaction with chip select still asserted");

  a_status_only_on_done: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.status != ST_OK |-> out_data.done_res)
    else $error("nonzero status on a transaction that is not done");

  a_reject_code_tied: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reject_code != 3'd0 |-> out_data.status == ST_REJECTED)
    else $error("reject code without write-rejected status");

  a_read_write_exclusive: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_data.read_valid && out_data.take_write))
    else $error("read data and write take in the same transaction");
`endif

endmodule

>>> tb/tb_mmc_spi_block_transfer_top.sv
// Self-checking testbench for mmc_spi_block_transfer_top: single-block SPI card reads and writes.
// A directed table is followed by randomized whole transfers under several limit settings.
// Depends on mmcsbt_pkg and the RTL under rtl/core.
`timescale 1ns / 100ps

module tb_mmc_spi_block_transfer_top;
  import mmcsbt_pkg::*;

  localparam logic [1:0]           ACT_SLOT_ALT = 2'd3;  // decodes as a slot
  localparam logic [CFG_IDX_W-1:0] REG_NONE     = 2'd3;  // past the register list
  localparam int HOLD_CYCLES = 300;
  localparam int STUCK_LIMIT = 3000;

  typedef enum logic [3:0] {
    PH_IDLE, PH_FRAME, PH_R1, PH_TOKEN, PH_RDATA, PH_RCRC, PH_WDATA, PH_WTAIL, PH_BUSY
  } card_phase_e;

  typedef enum int {
    OP_NOISE, OP_CUT, OP_READ_TOKTMO, OP_READ_OK, OP_WRITE_OK, OP_WRITE_REJ, OP_WRITE_BUSYTMO
  } transfer_kind_e;

  typedef struct packed {
    in_item_t  item;
    logic      typed;
    out_item_t want;
  } table_row_t;

  logic      clk = 1'b0;
  logic      rst_n;
  logic      in_valid;
  logic      in_stall;
  in_item_t  in_data;
  logic      out_valid;
  logic      out_stall;
  out_item_t out_data;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_wdata;

  // predicted card-side state and mirrored limits
  card_phase_e cp_phase = PH_IDLE;
  logic        cp_write = 1'b0;
  logic [31:0] cp_addr  = '0;
  logic [9:0]  cp_count = '0;
  logic [15:0] cp_tries = '0;
  logic [11:0] lim_resp = 12'd1024;
  logic [11:0] lim_tok  = 12'd1024;
  logic [15:0] lim_busy = 16'hFFFF;

  out_item_t  due_results[$];
  table_row_t dir_rows[$];
  int         in_taken = 0;
  int         out_taken = 0;
  int         stuck_cycles = 0;
  int         mismatches = 0;
  logic       pending_typed = 1'b0;
  out_item_t  pending_want = '0;
  logic       tx_idle_on = 1'b1;
  logic       rx_idle_on = 1'b1;
  logic       hold_req = 1'b0;

  mmc_spi_block_transfer_top dut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_wdata(cfg_wdata)
  );

  always begin
    #6 clk = 1'b1;
    #6 clk = 1'b0;
  end

  function automatic logic [7:0] cmd_frame_byte(logic [2:0] idx);
    case (idx)
      3'd0:    return CMD_BASE + (cp_write ? CMD_WRITE : CMD_READ);
      3'd1:    return cp_addr[31:24];
      3'd2:    return cp_addr[23:16];
      3'd3:    return cp_addr[15:8];
      3'd4:    return cp_addr[7:0];
      default: return FRAME_CRC;
    endcase
  endfunction

  function automatic out_item_t predict_exchange(in_item_t it);
    out_item_t r;
    logic      fin;
    r = '0;
    r.tx_byte = IDLE_BYTE;
    r.card_select = 1'b1;
    fin = 1'b0;
    if (it.action == ACT_READ || it.action == ACT_WRITE) begin
      cp_write = (it.action == ACT_WRITE);
      cp_addr  = it.block_address;
      cp_phase = PH_FRAME;
      cp_tries = '0;
      r.tx_byte = cmd_frame_byte(3'd0);
      cp_count = 10'd1;
    end else begin
      case (cp_phase)
        PH_FRAME: begin
          if (cp_count <= 10'd5) begin
            r.tx_byte = cmd_frame_byte(cp_count[2:0]);
            cp_count++;
          end else begin
            cp_phase = PH_R1;
            cp_tries = 16'd1;
          end
        end
        PH_R1: begin
          // R1 is not judged; a timeout just moves on
          if (!it.rx_byte[7] || cp_tries >= 16'(lim_resp)) begin
            if (cp_write) begin
              r.tx_byte = START_TOKEN;
              cp_phase = PH_WDATA;
              cp_count = '0;
            end else begin
              cp_phase = PH_TOKEN;
              cp_tries = 16'd1;
            end
          end else begin
            cp_tries++;
          end
        end
        PH_TOKEN: begin
          if (it.rx_byte == START_TOKEN) begin
            cp_phase = PH_RDATA;
            cp_count = '0;
          end else if (cp_tries >= 16'(lim_tok)) begin
            fin = 1'b1;
            r.status = ST_TOK_TMO;
          end else begin
            cp_tries++;
          end
        end
        PH_RDATA: begin
          r.read_valid = 1'b1;
          r.read_byte = it.rx_byte;
          if (cp_count >= 10'(BLOCK_BYTES - 1)) begin
            cp_phase = PH_RCRC;
            cp_count = '0;
          end else begin
            cp_count++;
          end
        end
        PH_RCRC: begin
          if (cp_count == '0) cp_count = 10'd1;
          else fin = 1'b1;
        end
        PH_WDATA: begin
          r.tx_byte = it.write_byte;
          r.take_write = 1'b1;
          if (cp_count >= 10'(BLOCK_BYTES - 1)) begin
            cp_phase = PH_WTAIL;
            cp_count = '0;
          end else begin
            cp_count++;
          end
        end
        PH_WTAIL: begin
          if (cp_count < 10'd3) begin
            cp_count++;
          end else if (it.rx_byte[3:1] != RESP_ACCEPT) begin
            fin = 1'b1;
            r.status = ST_REJECTED;
            r.reject_code = it.rx_byte[3:1];
          end else begin
            cp_phase = PH_BUSY;
            cp_tries = 16'd1;
          end
        end
        PH_BUSY: begin
          if (it.rx_byte != BUSY_BYTE) begin
            fin = 1'b1;
          end else if (cp_tries >= lim_busy) begin
            fin = 1'b1;
            r.status = ST_BUSY_TMO;
          end else begin
            cp_tries++;
          end
        end
        default: begin
          cp_phase = PH_IDLE;
          r.card_select = 1'b0;
        end
      endcase
      if (fin) begin
        cp_phase = PH_IDLE;
        r.card_select = 1'b0;
        r.done_res = 1'b1;
        r.tx_byte = IDLE_BYTE;
      end
    end
    return r;
  endfunction

  function automatic out_item_t result_of(logic [7:0] tx, logic cs, logic done, logic [1:0] st);
    out_item_t r;
    r = '0;
    r.tx_byte = tx;
    r.card_select = cs;
    r.done_res = done;
    r.status = st;
    return r;
  endfunction

  // a zero limit register behaves as a single poll
  function automatic int poll_cap(int lim);
    return (lim == 0) ? 1 : lim;
  endfunction

  task automatic flag_mismatch(string what, logic [31:0] got, logic [31:0] want);
    mismatches++;
    if (mismatches <= 40)
      $display("[%0t] result %0d: %s got 0x%0h, expected 0x%0h", $realtime, out_taken, what,
               got, want);
  endtask

  always @(posedge clk) begin : exchange_monitor
    out_item_t want;
    logic      moved;
    moved = 1'b0;
    if (rst_n) begin
      if (out_valid && !out_stall) begin
        moved = 1'b1;
        out_taken++;
        if (due_results.size() == 0) begin
          flag_mismatch("unexpected transaction", 32'(out_data), 32'd0);
        end else begin
          want = due_results.pop_front();
          if (out_data.tx_byte !== want.tx_byte)
            flag_mismatch("tx_byte", 32'(out_data.tx_byte), 32'(want.tx_byte));
          if (out_data.card_select !== want.card_select)
            flag_mismatch("card_select", 32'(out_data.card_select), 32'(want.card_select));
          if (out_data.take_write !== want.take_write)
            flag_mismatch("take_write", 32'(out_data.take_write), 32'(want.take_write));
          if (out_data.read_valid !== want.read_valid)
            flag_mismatch("read_valid", 32'(out_data.read_valid), 32'(want.read_valid));
          if (out_data.read_byte !== want.read_byte)
            flag_mismatch("read_byte", 32'(out_data.read_byte), 32'(want.read_byte));
          if (out_data.done_res !== want.done_res)
            flag_mismatch("done_res", 32'(out_data.done_res), 32'(want.done_res));
          if (out_data.status !== want.status)
            flag_mismatch("status", 32'(out_data.status), 32'(want.status));
          if (out_data.reject_code !== want.reject_code)
            flag_mismatch("reject_code", 32'(out_data.reject_code), 32'(want.reject_code));
        end
      end
      if (in_valid && !in_stall) begin
        moved = 1'b1;
        in_taken++;
        want = predict_exchange(in_data);
        if (pending_typed) want = pending_want;
        due_results.push_back(want);
      end
      stuck_cycles = moved ? 0 : stuck_cycles + 1;
    end
  end

  initial begin : watchdog
    wait (rst_n === 1'b1);
    while (stuck_cycles < STUCK_LIMIT) @(negedge clk);
    $display("Simulation FAILED");
    $finish;
  end

  // result side: random stall per transaction, plus one long hold on request
  initial begin : result_sink
    int w;
    int n0;
    out_stall = 1'b0;
    @(negedge clk);
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(negedge clk);
        hold_req = 1'b0;
      end else begin
        w = rx_idle_on ? $urandom_range(0, 18) : 0;
        if (w > 0) begin
          out_stall <= 1'b1;
          repeat (w) @(negedge clk);
        end
      end
      out_stall <= 1'b0;
      n0 = out_taken;
      do @(negedge clk); while (out_taken == n0);
    end
  end

  // called at a falling edge; returns at the falling edge after acceptance
  task automatic send_item(in_item_t it, logic typed, out_item_t want);
    int gap;
    int n0;
    gap = tx_idle_on ? $urandom_range(0, 18) : 0;
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(negedge clk);
    end
    in_valid <= 1'b1;
    in_data <= it;
    pending_typed = typed;
    pending_want = want;
    n0 = in_taken;
    do @(negedge clk); while (in_taken == n0);
  endtask

  task automatic exchange(logic [7:0] rx, logic [7:0] wb);
    in_item_t it;
    it.action = ($urandom_range(0, 15) == 0) ? ACT_SLOT_ALT : ACT_SLOT;
    it.block_address = $urandom;
    it.rx_byte = rx;
    it.write_byte = wb;
    send_item(it, 1'b0, '0);
  endtask

  task automatic add_row(logic [1:0] act, logic [31:0] addr, logic [7:0] rx, logic [7:0] wb,
                         logic typed, out_item_t want);
    dir_rows.push_back({act, addr, rx, wb, typed, want});
  endtask

  task automatic drain();
    in_valid <= 1'b0;
    while (due_results.size() != 0) @(negedge clk);
    repeat (4) @(negedge clk);
  endtask

  task automatic set_limits(logic [15:0] r, logic [15:0] t, logic [15:0] b);
    drain();
    cfg_we <= 1'b1;
    cfg_index <= REG_RESP_LIMIT;
    cfg_wdata <= {4'($urandom), r[11:0]};
    @(negedge clk);
    cfg_index <= REG_TOK_LIMIT;
    cfg_wdata <= {4'($urandom), t[11:0]};
    @(negedge clk);
    cfg_index <= REG_BUSY_LIMIT;
    cfg_wdata <= b;
    @(negedge clk);
    cfg_index <= REG_NONE;
    cfg_wdata <= 16'($urandom);
    @(negedge clk);
    cfg_we <= 1'b0;
    lim_resp = r[11:0];
    lim_tok = t[11:0];
    lim_busy = b;
  endtask

  task automatic run_op(transfer_kind_e kind);
    in_item_t   it;
    logic       wr;
    int         lim;
    int         n;
    logic [7:0] b;
    logic [2:0] code;
    if (kind == OP_NOISE) begin
      repeat ($urandom_range(1, 3)) exchange(8'($urandom), 8'($urandom));
      return;
    end
    wr = (kind == OP_WRITE_OK || kind == OP_WRITE_REJ || kind == OP_WRITE_BUSYTMO) ||
         (kind == OP_CUT && $urandom_range(0, 1) == 1);
    it.action = wr ? ACT_WRITE : ACT_READ;
    case ($urandom_range(0, 3))
      0:       it.block_address = 32'h0;
      1:       it.block_address = 32'hFFFF_FFFF;
      default: it.block_address = $urandom;
    endcase
    it.rx_byte = 8'($urandom);
    it.write_byte = 8'($urandom);
    send_item(it, 1'b0, '0);
    if (kind == OP_CUT) begin
      // left unfinished; the next start abandons it
      repeat ($urandom_range(0, 20)) exchange(8'($urandom), 8'($urandom));
      return;
    end
    repeat (6) exchange(8'($urandom), 8'($urandom));
    lim = poll_cap(int'(lim_resp));
    if (lim <= 64 && $urandom_range(0, 2) == 0) n = lim;
    else n = $urandom_range(0, (lim - 1 < 3) ? lim - 1 : 3);
    repeat (n) exchange(8'h80 | 8'($urandom), 8'($urandom));
    if (n < lim) exchange(8'($urandom) & 8'h7F, 8'($urandom));
    if (!wr) begin
      lim = poll_cap(int'(lim_tok));
      if (kind == OP_READ_TOKTMO) n = lim;
      else n = $urandom_range(0, (lim - 1 < 4) ? lim - 1 : 4);
      for (int i = 0; i < n; i++) begin
        do b = 8'($urandom); while (b == START_TOKEN);
        exchange(b, 8'($urandom));
      end
      if (kind == OP_READ_TOKTMO) return;
      exchange(START_TOKEN, 8'($urandom));
      repeat (BLOCK_BYTES + 2) exchange(8'($urandom), 8'($urandom));
    end else begin
      repeat (BLOCK_BYTES + 3) exchange(8'($urandom), 8'($urandom));
      if (kind == OP_WRITE_REJ) begin
        do code = 3'($urandom); while (code == RESP_ACCEPT);
        exchange({4'($urandom), code, 1'($urandom)}, 8'($urandom));
        return;
      end
      exchange({4'($urandom), RESP_ACCEPT, 1'($urandom)}, 8'($urandom));
      lim = poll_cap(int'(lim_busy));
      if (kind == OP_WRITE_BUSYTMO) n = lim;
      else n = $urandom_range(0, (lim - 1 < 5) ? lim - 1 : 5);
      repeat (n) exchange(BUSY_BYTE, 8'($urandom));
      if (kind != OP_WRITE_BUSYTMO) exchange(8'($urandom_range(1, 255)), 8'($urandom));
    end
  endtask

  initial begin : stimulus
    transfer_kind_e full_kind;
    transfer_kind_e kind;
    int             n_short;
    int             full_at;
    int             full_ph;
    out_item_t      idle_res;
    out_item_t      frame_res;
    rst_n = 1'b0;
    in_valid = 1'b0;
    in_data = '0;
    cfg_we = 1'b0;
    cfg_index = '0;
    cfg_wdata = '0;
    repeat (6) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // response limit 2, token limit zero (one poll)
    set_limits(16'd2, 16'd0, 16'hFFFF);
    idle_res = result_of(IDLE_BYTE, 1'b0, 1'b0, ST_OK);
    frame_res = result_of(IDLE_BYTE, 1'b1, 1'b0, ST_OK);
    add_row(ACT_SLOT, 32'h0, 8'hFF, 8'hFF, 1'b1, idle_res);
    add_row(ACT_SLOT_ALT, 32'hFFFF_FFFF, 8'h00, 8'h00, 1'b1, idle_res);
    add_row(ACT_READ, 32'hFFFF_FFFF, 8'h00, 8'hFF, 1'b1,
            result_of(CMD_BASE + CMD_READ, 1'b1, 1'b0, ST_OK));
    repeat (4) add_row(ACT_SLOT, 32'h0, 8'hFF, 8'h00, 1'b1, frame_res);
    add_row(ACT_SLOT, 32'h0, 8'hFF, 8'h00, 1'b1, result_of(FRAME_CRC, 1'b1, 1'b0, ST_OK));
    add_row(ACT_SLOT, 32'h0, 8'hFF, 8'h00, 1'b0, '0);
    add_row(ACT_SLOT, 32'h0, 8'h80, 8'h00, 1'b0, '0);
    add_row(ACT_SLOT, 32'h0, 8'h80, 8'h00, 1'b0, '0);   // R1 never arrives
    add_row(ACT_SLOT, 32'h0, 8'h00, 8'h00, 1'b1, result_of(IDLE_BYTE, 1'b0, 1'b1, ST_TOK_TMO));
    add_row(ACT_WRITE, 32'h0, 8'hFF, 8'h00, 1'b1,
            result_of(CMD_BASE + CMD_WRITE, 1'b1, 1'b0, ST_OK));
    repeat (6) add_row(ACT_SLOT, 32'hFFFF_FFFF, 8'hFF, 8'h00, 1'b0, '0);
    add_row(ACT_SLOT, 32'h0, 8'h01, 8'h00, 1'b0, '0);
    add_row(ACT_SLOT, 32'h0, 8'hFF, 8'hFF, 1'b0, '0);
    add_row(ACT_SLOT, 32'h0, 8'h00, 8'h00, 1'b0, '0);
    // start while a write is running
    add_row(ACT_READ, 32'h1234_5678, 8'h00, 8'h00, 1'b1,
            result_of(CMD_BASE + CMD_READ, 1'b1, 1'b0, ST_OK));
    add_row(ACT_SLOT, 32'h0, 8'h00, 8'h00, 1'b0, '0);
    foreach (dir_rows[i])
      send_item(dir_rows[i].item, dir_rows[i].typed, dir_rows[i].want);

    // one whole block transfer per run, in a phase picked at random
    full_ph = $urandom_range(0, 3);
    for (int ph = 0; ph < 5; ph++) begin
      case (ph)
        0: begin
          set_limits(16'd4095, 16'd4095, 16'hFFFF);
          full_kind = OP_READ_OK;
        end
        1: begin
          set_limits(16'd1, 16'd1, 16'd1);
          full_kind = OP_WRITE_BUSYTMO;
        end
        2: begin
          set_limits(16'd1024, 16'd1024, 16'hFFFF);
          full_kind = OP_WRITE_REJ;
        end
        3: begin
          set_limits(16'd0, 16'd0, 16'd0);
          full_kind = OP_WRITE_OK;
        end
        default: begin
          set_limits(16'($urandom_range(1, 40)), 16'($urandom_range(1, 40)),
                     16'($urandom_range(1, 40)));
          full_kind = OP_NOISE;
        end
      endcase
      n_short = (ph < 4) ? $urandom_range(2, 4) : $urandom_range(8, 12);
      full_at = $urandom_range(0, n_short);
      for (int k = 0; k <= n_short; k++) begin
        tx_idle_on = ($urandom_range(0, 3) != 0);
        rx_idle_on = ($urandom_range(0, 3) != 0);
        if (k == full_at && ph == full_ph) begin
          hold_req = 1'b1;
          run_op(full_kind);
        end else begin
          case ($urandom_range(0, 3))
            0:       kind = OP_NOISE;
            1:       kind = (poll_cap(int'(lim_tok)) <= 64) ? OP_READ_TOKTMO : OP_CUT;
            default: kind = OP_CUT;
          endcase
          run_op(kind);
        end
      end
    end

    drain();
    if (mismatches == 0) $display("Simulation PASSED");
    else $display("Simulation FAILED");
    $finish;
  end

endmodule
